// ===== sv/jep_pkg.sv =====
`default_nettype none

package jep_pkg;

  // Default circle capacity; the top level hands it down as a parameter.
  localparam int unsigned MAX_PEOPLE_DEF = 64;

  localparam int unsigned UPC_W = 4;

  // Result kinds as they appear on the kind port.
  typedef enum logic [1:0] {
    KIND_ELIMINATED = 2'd0,
    KIND_LEADER     = 2'd1,
    KIND_NO_LEADER  = 2'd2
  } jep_kind_e;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SETUP,
    OP_ROUND,
    OP_WALK,
    OP_REMOVE,
    OP_LEADER,
    OP_EMPTY
  } jep_op_e;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_EMPTY,
    COND_INIT_MORE,
    COND_REM_LE1,
    COND_M_ONE,
    COND_WALK_MORE
  } jep_cond_e;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] UA_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] UA_CHECK  = 4'd1;
  localparam logic [UPC_W-1:0] UA_INIT   = 4'd2;
  localparam logic [UPC_W-1:0] UA_SETUP  = 4'd3;
  localparam logic [UPC_W-1:0] UA_ROUND  = 4'd4;
  localparam logic [UPC_W-1:0] UA_MCHECK = 4'd5;
  localparam logic [UPC_W-1:0] UA_WALK   = 4'd6;
  localparam logic [UPC_W-1:0] UA_REMOVE = 4'd7;
  localparam logic [UPC_W-1:0] UA_LEADER = 4'd8;
  localparam logic [UPC_W-1:0] UA_EMPTY  = 4'd9;

  typedef struct packed {
    jep_op_e          op;
    jep_cond_e        cond;
    logic [UPC_W-1:0] target;
  } jep_uword_t;

  // Status flags from the datapath that the jump conditions look at.
  typedef struct packed {
    logic start;
    logic empty;
    logic init_more;
    logic rem_le1;
    logic m_one;
    logic walk_more;
  } jep_flags_t;

  // The control store. A taken condition jumps to target, otherwise the
  // sequencer falls through to the next address.
  function automatic jep_uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    jep_uword_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: UA_IDLE};
    unique case (addr)
      UA_IDLE:   w = '{op: OP_LOAD,   cond: COND_NO_START,  target: UA_IDLE};
      UA_CHECK:  w = '{op: OP_NONE,   cond: COND_EMPTY,     target: UA_EMPTY};
      UA_INIT:   w = '{op: OP_INIT,   cond: COND_INIT_MORE, target: UA_INIT};
      UA_SETUP:  w = '{op: OP_SETUP,  cond: COND_NEVER,     target: UA_IDLE};
      UA_ROUND:  w = '{op: OP_ROUND,  cond: COND_REM_LE1,   target: UA_LEADER};
      UA_MCHECK: w = '{op: OP_NONE,   cond: COND_M_ONE,     target: UA_REMOVE};
      UA_WALK:   w = '{op: OP_WALK,   cond: COND_WALK_MORE, target: UA_WALK};
      UA_REMOVE: w = '{op: OP_REMOVE, cond: COND_ALWAYS,    target: UA_ROUND};
      UA_LEADER: w = '{op: OP_LEADER, cond: COND_ALWAYS,    target: UA_IDLE};
      UA_EMPTY:  w = '{op: OP_EMPTY,  cond: COND_ALWAYS,    target: UA_IDLE};
      default:   w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/josephus_elimination_order.sv =====
// The successor table is built first; the removals then follow one round at a time, with
// each removal result in the cycle after its remove step; the leader follows the last removal.
// Only one transaction is in flight at a time.
// The pointer walk through the successor memory goes one link per cycle.
// Reset clears the sequencer and all control registers; the successor memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module josephus_elimination_order #(
  parameter int unsigned MAX_PEOPLE = jep_pkg::MAX_PEOPLE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [6:0]  people_count_i,
  input  wire logic [7:0]  step_i,
  output logic             result_valid_o,
  output logic [6:0]       person_o,
  output logic [1:0]       kind_o,
  output logic             last_o
);

  // The sequencer steps through a small control store. Each control word
  // names one datapath operation and one jump condition; the datapath hands
  // back status flags that the conditions test. A transaction is accepted in
  // the idle step when start_i is high, which also loads the saturated count
  // and the step.
  //
  // The datapath first builds the circular successor table, one entry per
  // cycle, and then runs rounds. Each round reads the successor of the head,
  // walks M - 1 links at one link per cycle, and unlinks the person it lands
  // on while emitting that person as eliminated. When one person is left,
  // that person is emitted as leader with last set. An empty circle produces
  // a single no-leader result.

  jep_pkg::jep_flags_t flags;
  jep_pkg::jep_op_e    op;

  jep_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op),
    .busy_o  (busy_o)
  );

  jep_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .people_count_i (people_count_i),
    .step_i         (step_i),
    .op_i           (op),
    .flags_o        (flags),
    .result_valid_o (result_valid_o),
    .person_o       (person_o),
    .kind_o         (kind_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== sv/jep_sequencer.sv =====
`default_nettype none

module jep_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jep_pkg::jep_flags_t flags_i,
  output jep_pkg::jep_op_e        op_o,
  output logic                    busy_o
);

  logic [jep_pkg::UPC_W-1:0] upc_q, upc_d;
  jep_pkg::jep_uword_t       uword;
  logic                      taken;

  always_comb begin
    uword = jep_pkg::ucode_rom(upc_q);
    unique case (uword.cond)
      jep_pkg::COND_NEVER:     taken = 1'b0;
      jep_pkg::COND_ALWAYS:    taken = 1'b1;
      jep_pkg::COND_NO_START:  taken = !flags_i.start;
      jep_pkg::COND_EMPTY:     taken = flags_i.empty;
      jep_pkg::COND_INIT_MORE: taken = flags_i.init_more;
      jep_pkg::COND_REM_LE1:   taken = flags_i.rem_le1;
      jep_pkg::COND_M_ONE:     taken = flags_i.m_one;
      jep_pkg::COND_WALK_MORE: taken = flags_i.walk_more;
      default:                 taken = 1'b1;
    endcase
    upc_d = taken ? uword.target : upc_q + 1'b1;
    // The load only happens on the cycle a transaction is taken.
    if (uword.op == jep_pkg::OP_LOAD && !flags_i.start) begin
      op_o = jep_pkg::OP_NONE;
    end else begin
      op_o = uword.op;
    end
  end

  assign busy_o = (upc_q != jep_pkg::UA_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= jep_pkg::UA_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/jep_datapath.sv =====
`default_nettype none

module jep_datapath #(
  parameter int unsigned MAX_PEOPLE = jep_pkg::MAX_PEOPLE_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [6:0]      people_count_i,
  input  wire logic [7:0]      step_i,
  input  wire jep_pkg::jep_op_e op_i,
  output jep_pkg::jep_flags_t  flags_o,
  output logic                 result_valid_o,
  output logic [6:0]           person_o,
  output logic [1:0]           kind_o,
  output logic                 last_o
);

  localparam int unsigned IW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam int unsigned NW = $clog2(MAX_PEOPLE + 1);

  logic [IW-1:0] link_mem [MAX_PEOPLE];

  logic [NW-1:0] n_q, rem_q;
  logic [7:0]    mstep_q, k_q;
  logic [IW-1:0] idx_q, cur_q, prev_q, p_q, rd_q;
  logic          valid_q, last_q;
  logic [6:0]    person_q;
  logic [1:0]    kind_q;

  logic [NW-1:0] n_sat;
  logic [NW:0]   idx_next;
  logic [IW-1:0] init_link;
  logic          wr_en;
  logic [IW-1:0] wr_addr, wr_data, rd_addr;

  always_comb begin
    if (people_count_i > 7'(MAX_PEOPLE)) begin
      n_sat = NW'(MAX_PEOPLE);
    end else begin
      n_sat = NW'(people_count_i);
    end
    idx_next  = (NW + 1)'(idx_q) + 1'b1;
    init_link = (idx_next < (NW + 1)'(n_q)) ? IW'(idx_next) : '0;

    wr_en   = (op_i == jep_pkg::OP_INIT) || (op_i == jep_pkg::OP_REMOVE);
    wr_addr = (op_i == jep_pkg::OP_INIT) ? idx_q : prev_q;
    wr_data = (op_i == jep_pkg::OP_INIT) ? init_link : rd_q;
    rd_addr = (op_i == jep_pkg::OP_WALK) ? rd_q : cur_q;

    flags_o.start     = start_i;
    flags_o.empty     = (n_q == '0);
    flags_o.init_more = (NW'(idx_q) != n_q - 1'b1);
    flags_o.rem_le1   = (rem_q <= NW'(1));
    flags_o.m_one     = (mstep_q == 8'd0);
    flags_o.walk_more = (k_q != 8'd1);
  end

  // Successor table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (op_i == jep_pkg::OP_ROUND || op_i == jep_pkg::OP_WALK) begin
      rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      rem_q    <= '0;
      mstep_q  <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      cur_q    <= '0;
      prev_q   <= '0;
      p_q      <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      person_q <= '0;
      kind_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (op_i)
        jep_pkg::OP_LOAD: begin
          n_q     <= n_sat;
          mstep_q <= (step_i == 8'd0) ? 8'd0 : step_i - 8'd1;
          idx_q   <= '0;
        end
        jep_pkg::OP_INIT: begin
          idx_q <= idx_q + 1'b1;
        end
        jep_pkg::OP_SETUP: begin
          cur_q  <= '0;
          prev_q <= IW'(n_q - 1'b1);
          rem_q  <= n_q;
        end
        jep_pkg::OP_ROUND: begin
          p_q <= cur_q;
          k_q <= mstep_q;
        end
        jep_pkg::OP_WALK: begin
          prev_q <= p_q;
          p_q    <= rd_q;
          k_q    <= k_q - 8'd1;
        end
        jep_pkg::OP_REMOVE: begin
          cur_q    <= rd_q;
          rem_q    <= rem_q - 1'b1;
          valid_q  <= 1'b1;
          person_q <= 7'(p_q) + 7'd1;
          kind_q   <= jep_pkg::KIND_ELIMINATED;
          last_q   <= 1'b0;
        end
        jep_pkg::OP_LEADER: begin
          valid_q  <= 1'b1;
          person_q <= 7'(cur_q) + 7'd1;
          kind_q   <= jep_pkg::KIND_LEADER;
          last_q   <= 1'b1;
        end
        jep_pkg::OP_EMPTY: begin
          valid_q  <= 1'b1;
          person_q <= '0;
          kind_q   <= jep_pkg::KIND_NO_LEADER;
          last_q   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign person_o       = person_q;
  assign kind_o         = kind_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== tb/josephus_order_checker.sv =====
`timescale 1ns / 100ps

module josephus_order_checker #(
  parameter int unsigned MAX_PEOPLE = jep_pkg::MAX_PEOPLE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       busy_i,
  input  wire logic [6:0] people_count_i,
  input  wire logic [7:0] step_i,
  input  wire logic       result_valid_i,
  input  wire logic [6:0] person_i,
  input  wire logic [1:0] kind_i,
  input  wire logic       last_i,
  output int              outstanding_o,
  output int              fail_count_o
);

  typedef struct packed {
    logic [6:0]         person;
    jep_pkg::jep_kind_e kind;
    logic               last;
  } removal_t;

  removal_t removal_q[$];

  initial begin
    outstanding_o = 0;
    fail_count_o  = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic void push_removal(input logic [6:0] person,
                                       input jep_pkg::jep_kind_e kind,
                                       input logic last);
    removal_t r;
    r.person = person;
    r.kind   = kind;
    r.last   = last;
    removal_q.push_back(r);
  endfunction

  // Plays the whole elimination for one request and queues every result it yields.
  function automatic void predict_elimination(input logic [6:0] count, input logic [7:0] step);
    logic [5:0] succ [64];
    logic [5:0] head, behind, walk, walk_prev;
    int unsigned n, m, left;
    n = (count > MAX_PEOPLE) ? MAX_PEOPLE : count;
    m = (step == 8'd0) ? 1 : step;
    if (n == 0) begin
      push_removal(7'd0, jep_pkg::KIND_NO_LEADER, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      succ[i] = (i + 1 < n) ? 6'(i + 1) : 6'd0;
    end
    head   = 6'd0;
    behind = 6'(n - 1);
    left   = n;
    while (left > 1) begin
      walk      = head;
      walk_prev = behind;
      for (int unsigned k = 0; k + 1 < m; k++) begin
        walk_prev = walk;
        walk      = succ[walk];
      end
      succ[walk_prev] = succ[walk];
      head            = succ[walk];
      behind          = walk_prev;
      left--;
      push_removal({1'b0, walk} + 7'd1, jep_pkg::KIND_ELIMINATED, 1'b0);
    end
    push_removal({1'b0, head} + 7'd1, jep_pkg::KIND_LEADER, 1'b1);
  endfunction

  // Results are checked before a new request is queued, since a result seen at
  // the same edge always belongs to an earlier request.
  always @(posedge clk_i) begin
    removal_t exp_r;
    if (rst_ni) begin
      if (result_valid_i) begin
        if (removal_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result person=%0d kind=%0d last=%0d",
                                    person_i, kind_i, last_i));
        end else begin
          exp_r = removal_q.pop_front();
          if (person_i !== exp_r.person)
            report_mismatch($sformatf("person %0d, expected %0d", person_i, exp_r.person));
          if (kind_i !== exp_r.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind_i, exp_r.kind));
          if (last_i !== exp_r.last)
            report_mismatch($sformatf("last %0d, expected %0d", last_i, exp_r.last));
        end
      end
      if (start_i && !busy_i) predict_elimination(people_count_i, step_i);
      outstanding_o = removal_q.size();
    end
  end

endmodule

// ===== tb/tb_josephus_elimination_order.sv =====
`timescale 1ns / 100ps

module tb_josephus_elimination_order;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RANDOM_ITEMS = 80;
  // The last stretch of random requests is sent back to back with no idling.
  localparam int unsigned STEADY_TAIL  = 20;
  // Once the last result has come the block only returns to idle, so a short
  // settle window is enough to catch any stray result.
  localparam int unsigned SETTLE_CYCLES = 100;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [6:0] people_count;
  logic [7:0] step;
  logic       result_valid;
  logic [6:0] person;
  logic [1:0] kind;
  logic       last;
  int         outstanding;
  int         mismatches;

  josephus_elimination_order dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .people_count_i (people_count),
    .step_i         (step),
    .result_valid_o (result_valid),
    .person_o       (person),
    .kind_o         (kind),
    .last_o         (last)
  );

  // The checker watches both channels on its own, so this module only has to
  // produce requests and read back the failure count at the end.
  josephus_order_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .people_count_i (people_count),
    .step_i         (step),
    .result_valid_i (result_valid),
    .person_i       (person),
    .kind_i         (kind),
    .last_i         (last),
    .outstanding_o  (outstanding),
    .fail_count_o   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop. The worst request is a full circle with step 255; even if every
  // request in the run hit that case, the whole run stays well under a third
  // of this bound.
  initial begin
    #100_000_000;
    $display("josephus_elimination_order: mismatch");
    $finish;
  end

  // Presents one request and holds it until the block takes it. The transaction
  // completes at the rising edge where start is high and busy is low. Start is
  // left high afterwards so that a following request can go out back to back.
  task automatic send_request(input logic [6:0] count, input logic [7:0] m);
    @(negedge clk);
    start        <= 1'b1;
    people_count <= count;
    step         <= m;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Drops start for a number of cycles. The payload ports carry junk meanwhile,
  // which the block must ignore because start is low.
  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      people_count <= 7'($urandom);
      step         <= 8'($urandom);
    end
  endtask

  // Holds off new requests until every predicted result has been seen.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [6:0]  count;
    logic [7:0]  m;
    int unsigned pick;

    start        = 1'b0;
    people_count = 7'd0;
    step         = 8'd0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests. An empty circle gives the lone no-leader result, and a
    // single person gives only a leader. A zero step must act like step one.
    send_request(7'd0, 8'd5);
    send_request(7'd0, 8'd0);
    send_request(7'd1, 8'd0);
    send_request(7'd1, 8'd255);
    send_request(7'd2, 8'd0);
    send_request(7'd2, 8'd1);
    send_request(7'd2, 8'd2);
    send_request(7'd5, 8'd2);
    send_request(7'd7, 8'd3);
    send_request(7'd41, 8'd3);
    send_request(7'd6, 8'd6);
    send_request(7'd3, 8'd7);
    send_request(7'd10, 8'd255);
    // Full circle and beyond: counts above the capacity saturate to it.
    send_request(7'd63, 8'd2);
    send_request(7'd64, 8'd0);
    send_request(7'd64, 8'd1);
    send_request(7'd64, 8'd255);
    send_request(7'd65, 8'd2);
    send_request(7'd100, 8'd17);
    send_request(7'd127, 8'd128);
    send_request(7'd127, 8'd255);

    // Let the block empty out completely once before the random part.
    wait_for_drain();

    // Random requests. Most use small circles and short steps to keep the run
    // short; a few use the full field ranges so every input bit gets exercised
    // and the long pointer walks are covered.
    for (int unsigned idx = 0; idx < RANDOM_ITEMS; idx++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        count = 7'($urandom_range(0, 127));
        m     = 8'($urandom_range(0, 255));
      end else if (pick == 1) begin
        count = 7'($urandom_range(60, 127));
        m     = 8'($urandom_range(0, 6));
      end else begin
        count = 7'($urandom_range(0, 70));
        m     = 8'($urandom_range(0, 9));
      end
      send_request(count, m);
      if (idx < RANDOM_ITEMS - STEADY_TAIL) begin
        if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 15));
        if ($urandom_range(0, 24) == 0) wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("josephus_elimination_order: match");
    end else begin
      $display("josephus_elimination_order: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/jep_pkg.sv
sv/jep_sequencer.sv
sv/jep_datapath.sv
sv/josephus_elimination_order.sv
tb/josephus_order_checker.sv
tb/tb_josephus_elimination_order.sv
